/* rtl/core/assert_macros.svh */
// assertion macros used by the led chain encoder datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, checked on every rising edge outside reset
`define LCPE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// invariant that must hold on every rising edge outside reset
`define LCPE_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

/* rtl/core/lcpe_pkg.sv */
// package with constants and controller/datapath interface types of the led chain encoder
`default_nettype none

package lcpe_pkg;

    localparam int MaxLedsDefault = 1024;

    localparam int ActiveTicks  = 17;
    localparam int PassiveTicks = 40;
    localparam int NsPerTick    = 25;

    localparam logic [15:0] ActiveNs  = 16'(ActiveTicks * NsPerTick);
    localparam logic [15:0] PassiveNs = 16'(PassiveTicks * NsPerTick);

    localparam int GroupSlots = 64;
    localparam int PosW       = $clog2(GroupSlots);

    localparam int CfgIndexW = 2;
    localparam int CfgDataW  = 10;

    localparam logic [CfgIndexW-1:0] RegLedType  = 2'd0;
    localparam logic [CfgIndexW-1:0] RegInvert   = 2'd1;
    localparam logic [CfgIndexW-1:0] RegLedLimit = 2'd2;

    localparam logic [1:0] LedGrb  = 2'd0;
    localparam logic [1:0] LedGrbw = 2'd1;
    localparam logic [1:0] LedRgb  = 2'd2;

    localparam logic [4:0] LastBitNarrow = 5'd23;
    localparam logic [4:0] LastBitWide   = 5'd31;

    typedef struct packed {
        logic load;
        logic put;
        logic level;
        logic next_bit;
        logic flush;
    } dp_cmd_t;

    typedef struct packed {
        logic encode_ok;
        logic cur_bit;
        logic last_bit;
        logic pos_last;
        logic pos_zero;
        logic frame_end;
        logic put_ok;
        logic flush_ok;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/led_chain_pwm_pattern_encoder_core.sv */
// top level of the led chain pwm slot encoder
`default_nettype none

// Encodes one LED per input transfer into line slots: each colour bit, most
// significant first, becomes 1-1-0 for a one or 1-0 for a zero, packed lsb
// first into 64-slot groups with their transmit time in ns. One slot is
// produced per clock by the datapath while no finished group waits for the
// output side. An LED is loaded, its 24 or 32 bits become slots, plus a zero
// slot for each one that is pushed past a group boundary, a padding check
// follows, with zero slots up to the group end on the frame end, and a flush
// step ends it; an LED over the limit gets no bit slots. Slot, padding and
// flush steps stall while finished groups wait for the output side. A new LED
// is taken only after the previous one has been fully encoded. Configuration
// writes are always ready and must only be made while the block is idle.
module led_chain_pwm_pattern_encoder_core #(
    parameter int MAX_LEDS = lcpe_pkg::MaxLedsDefault
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // color_byte0 [7:0], color_byte1 [15:8], color_byte2 [23:16], color_byte3 [31:24]
    input  wire logic [31:0]                    s_tdata,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // slot_group [63:0], group_duration_ns [79:64]
    output logic [79:0]                         m_tdata,
    output logic                                m_tlast,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lcpe_pkg::CfgIndexW-1:0] cfg_index,
    input  wire logic [lcpe_pkg::CfgDataW-1:0]  cfg_data
);

    lcpe_pkg::dp_cmd_t    cmd;
    lcpe_pkg::dp_status_t status;
    logic                 in_ready;
    logic [lcpe_pkg::GroupSlots-1:0] out_group;
    logic [15:0]          out_duration;

    assign cfg_ready = 1'b1;
    assign s_tready  = in_ready;
    assign m_tdata   = {out_duration, out_group};

    lcpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lcpe_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_data      (s_tdata),
        .in_last      (s_tlast),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_group    (out_group),
        .out_duration (out_duration),
        .out_last     (m_tlast)
    );

endmodule

`default_nettype wire

/* rtl/core/lcpe_ctrl.sv */
// controller state machine sequencing bits, slots, padding and group flush
`default_nettype none

module lcpe_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lcpe_pkg::dp_status_t status,
    output lcpe_pkg::dp_cmd_t        cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SLOT  = 4'b0010,
        ST_PAD   = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_TAIL   = 2'd2
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        logic bit_done;
        bit_done   = 1'b0;
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = PH_FIRST;
                    state_next = status.encode_ok ? ST_SLOT : ST_PAD;
                end
            end
            ST_SLOT:
            begin
                if (status.put_ok)
                begin
                    cmd.put = 1'b1;
                    case (phase_reg)
                        PH_FIRST:
                        begin
                            // a one may not start on the last slot of a group
                            if (status.cur_bit && status.pos_last)
                            begin
                                cmd.level = 1'b0;
                            end
                            else
                            begin
                                cmd.level  = 1'b1;
                                phase_next = PH_SECOND;
                            end
                        end
                        PH_SECOND:
                        begin
                            if (status.cur_bit)
                            begin
                                cmd.level  = 1'b1;
                                phase_next = PH_TAIL;
                            end
                            else
                            begin
                                cmd.level = 1'b0;
                                bit_done  = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.level = 1'b0;
                            bit_done  = 1'b1;
                        end
                    endcase
                    if (bit_done)
                    begin
                        phase_next = PH_FIRST;
                        if (status.last_bit)
                        begin
                            state_next = ST_PAD;
                        end
                        else
                        begin
                            cmd.next_bit = 1'b1;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                if (!status.frame_end || status.pos_zero)
                begin
                    state_next = ST_FLUSH;
                end
                else if (status.put_ok)
                begin
                    cmd.put   = 1'b1;
                    cmd.level = 1'b0;
                end
            end
            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (status.flush_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/lcpe_datapath.sv */
// datapath: config registers, bit shifter, slot packing, durations, pending and output groups
`default_nettype none
`include "assert_macros.svh"

module lcpe_datapath #(
    parameter int MAX_LEDS = lcpe_pkg::MaxLedsDefault
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    input  wire logic [lcpe_pkg::CfgIndexW-1:0]     cfg_index,
    input  wire logic [lcpe_pkg::CfgDataW-1:0]      cfg_data,
    input  wire logic [31:0]                        in_data,
    input  wire logic                               in_last,
    input  wire lcpe_pkg::dp_cmd_t                  cmd,
    output lcpe_pkg::dp_status_t                    status,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [lcpe_pkg::GroupSlots-1:0]         out_group,
    output logic [15:0]                             out_duration,
    output logic                                    out_last
);

    localparam int LedCap = (MAX_LEDS < 1023) ? MAX_LEDS : 1023;
    localparam int CntW   = $clog2(LedCap + 1);
    localparam int PosW   = lcpe_pkg::PosW;
    localparam logic [15:0] DurMax = 16'((lcpe_pkg::GroupSlots - 1) * lcpe_pkg::PassiveTicks
                                         * lcpe_pkg::NsPerTick);

    logic [1:0]  led_type_reg;
    logic        invert_reg;
    logic [9:0]  led_limit_reg;

    logic [31:0] word_reg;
    logic [4:0]  bit_cnt_reg;
    logic        wide_reg;
    logic        frame_end_reg;
    logic [CntW-1:0] leds_reg;

    logic [lcpe_pkg::GroupSlots-1:0] partial_reg;
    logic [PosW-1:0]                 pos_reg;
    logic [15:0]                     dur_reg;

    logic                            pend_valid_reg;
    logic [lcpe_pkg::GroupSlots-1:0] pend_group_reg;
    logic [15:0]                     pend_dur_reg;

    logic                            out_valid_reg;
    logic [lcpe_pkg::GroupSlots-1:0] out_group_reg;
    logic [15:0]                     out_dur_reg;
    logic                            out_last_reg;

    logic        encode_ok;
    logic        pos_last;
    logic        out_free;
    logic        put_ok;
    logic        flush_ok;
    logic        completing;
    logic        slot_bit;
    logic [15:0] dur_inc;
    logic [15:0] dur_sum;
    logic        pend_to_out;
    logic [31:0] load_word;
    logic        load_wide;

    assign encode_ok  = (10'(leds_reg) < led_limit_reg) && (32'(leds_reg) < 32'(MAX_LEDS));
    assign pos_last   = (pos_reg == {PosW{1'b1}});
    assign out_free   = !out_valid_reg || out_ready;
    assign put_ok     = !pos_last || !pend_valid_reg || out_free;
    assign flush_ok   = !pend_valid_reg || out_free;
    assign completing = cmd.put && pos_last;
    assign slot_bit   = cmd.level ^ invert_reg;
    assign dur_inc    = cmd.level ? lcpe_pkg::ActiveNs : lcpe_pkg::PassiveNs;
    assign dur_sum    = dur_reg + dur_inc;
    assign pend_to_out = pend_valid_reg && ((completing) || (cmd.flush && out_free));

    always_comb
    begin
        status.encode_ok = encode_ok;
        status.cur_bit   = word_reg[31];
        status.last_bit  = (bit_cnt_reg == (wide_reg ? lcpe_pkg::LastBitWide
                                                     : lcpe_pkg::LastBitNarrow));
        status.pos_last  = pos_last;
        status.pos_zero  = (pos_reg == '0);
        status.frame_end = frame_end_reg;
        status.put_ok    = put_ok;
        status.flush_ok  = flush_ok;
    end

    // byte order on the wire
    always_comb
    begin
        case (led_type_reg)
            lcpe_pkg::LedGrbw:
            begin
                load_word = {in_data[15:8], in_data[7:0], in_data[23:16], in_data[31:24]};
                load_wide = 1'b1;
            end
            lcpe_pkg::LedRgb:
            begin
                load_word = {in_data[7:0], in_data[15:8], in_data[23:16], 8'h00};
                load_wide = 1'b0;
            end
            default:
            begin
                load_word = {in_data[15:8], in_data[7:0], in_data[23:16], 8'h00};
                load_wide = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_type_reg  <= lcpe_pkg::LedGrb;
            invert_reg    <= 1'b0;
            led_limit_reg <= 10'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lcpe_pkg::RegLedType:  led_type_reg  <= cfg_data[1:0];
                lcpe_pkg::RegInvert:   invert_reg    <= cfg_data[0];
                lcpe_pkg::RegLedLimit: led_limit_reg <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_end_reg <= 1'b0;
            leds_reg      <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                frame_end_reg <= in_last;
            end
            if (cmd.load && encode_ok)
            begin
                leds_reg <= leds_reg + CntW'(1);
            end
            else if (cmd.flush && flush_ok && frame_end_reg)
            begin
                leds_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg    <= load_word;
            wide_reg    <= load_wide;
            bit_cnt_reg <= '0;
        end
        else if (cmd.next_bit)
        begin
            word_reg    <= {word_reg[30:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pos_reg     <= '0;
            dur_reg     <= '0;
        end
        else if (cmd.put)
        begin
            pos_reg <= pos_reg + PosW'(1);
            if (completing)
            begin
                partial_reg <= '0;
                dur_reg     <= '0;
            end
            else
            begin
                partial_reg[pos_reg] <= slot_bit;
                dur_reg              <= dur_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (completing)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (cmd.flush && flush_ok)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (completing)
        begin
            pend_group_reg <= {slot_bit, partial_reg[lcpe_pkg::GroupSlots-2:0]};
            pend_dur_reg   <= dur_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pend_to_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // a group is marked last only when it closes the step of a frame end
    always_ff @(posedge clk)
    begin
        if (pend_to_out)
        begin
            out_group_reg <= pend_group_reg;
            out_dur_reg   <= pend_dur_reg;
            out_last_reg  <= cmd.flush && frame_end_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_group    = out_group_reg;
    assign out_duration = out_dur_reg;
    assign out_last     = out_last_reg;

    `LCPE_ASSERT(a_no_group_lost, clk, rst_n, (completing && pend_valid_reg) |-> out_free, "group completed while output register full")
    `LCPE_ASSERT(a_frame_aligned, clk, rst_n, (cmd.flush && flush_ok && frame_end_reg) |-> (pos_reg == '0), "frame closed with slots still open")
    `LCPE_ASSERT_ALWAYS(a_tail_clear, clk, rst_n, (partial_reg >> pos_reg) == '0, "stale slot bits above slot position")
    `LCPE_ASSERT_ALWAYS(a_dur_bound, clk, rst_n, dur_reg <= DurMax, "open group duration out of range")

endmodule

`default_nettype wire
